// ----- hdl/fft_grid_index_and_norm_classifier_core_macros.svh -----
// assertion macros for the grid index and norm classifier
`ifndef FFT_GRID_INDEX_AND_NORM_CLASSIFIER_CORE_MACROS_SVH
`define FFT_GRID_INDEX_AND_NORM_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FGNC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FGNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FGNC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FGNC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/fgnc_pkg.sv -----
// package: widths and default parameters of the grid index and norm classifier
`default_nettype none
package fgnc_pkg;
	localparam int GRID_W  = 6;
	localparam int WAVE_W  = 24;
	localparam int INDEX_W = 19;
	localparam int NORM_W  = 48;
	localparam int ID_W    = 8;

	localparam int GRID_X_DEF      = 64;
	localparam int GRID_Y_DEF      = 64;
	localparam int GRID_Z_DEF      = 64;
	localparam int CLASS_LIMIT_DEF = 256;
endpackage
`default_nettype wire

// ----- hdl/fgnc_in_if.sv -----
// input channel: one lattice vector per transfer
`default_nettype none
interface fgnc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   first_of_set;
	logic signed [fgnc_pkg::GRID_W-1:0]     grid_x;
	logic signed [fgnc_pkg::GRID_W-1:0]     grid_y;
	logic signed [fgnc_pkg::GRID_W-1:0]     grid_z;
	logic signed [fgnc_pkg::WAVE_W-1:0]     wave_x;
	logic signed [fgnc_pkg::WAVE_W-1:0]     wave_y;
	logic signed [fgnc_pkg::WAVE_W-1:0]     wave_z;

	modport source (
		output valid, first_of_set, grid_x, grid_y, grid_z, wave_x, wave_y, wave_z,
		input  ready
	);
	modport sink (
		input  valid, first_of_set, grid_x, grid_y, grid_z, wave_x, wave_y, wave_z,
		output ready
	);
endinterface
`default_nettype wire

// ----- hdl/fgnc_out_if.sv -----
// output channel: index, norm and class label per transfer
`default_nettype none
interface fgnc_out_if;
	logic                               valid;
	logic                               ready;
	logic [fgnc_pkg::INDEX_W-1:0]       buffer_index;
	logic [fgnc_pkg::NORM_W-1:0]        norm_squared;
	logic [fgnc_pkg::ID_W-1:0]          class_id;
	logic                               class_overflow;

	modport source (
		output valid, buffer_index, norm_squared, class_id, class_overflow,
		input  ready
	);
	modport sink (
		input  valid, buffer_index, norm_squared, class_id, class_overflow,
		output ready
	);
endinterface
`default_nettype wire

// ----- hdl/fft_grid_index_and_norm_classifier_core.sv -----
// sequence: index and norm in S_SQUARE, then the table scan in S_SEARCH, skipped for a first_of_set item
// one item at a time: a new item is taken only in S_IDLE, after the last one has reached the output register
// the scan reads one stored class norm per cycle from a table memory with one write and one read port
// the norm uses one shared 24x24 multiplier for the x, y and z squares in turn
// reset clears state, class count and error flag; table contents stay undefined
`default_nettype none
`include "fft_grid_index_and_norm_classifier_core_macros.svh"
module fft_grid_index_and_norm_classifier_core #(
	parameter int GRID_X      = fgnc_pkg::GRID_X_DEF,
	parameter int GRID_Y      = fgnc_pkg::GRID_Y_DEF,
	parameter int GRID_Z      = fgnc_pkg::GRID_Z_DEF,
	parameter int CLASS_LIMIT = fgnc_pkg::CLASS_LIMIT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fgnc_in_if.sink           item,
	fgnc_out_if.source        result
);
	localparam int IW    = fgnc_pkg::INDEX_W;
	localparam int GW    = fgnc_pkg::GRID_W;
	localparam int WW    = fgnc_pkg::WAVE_W;
	localparam int NW    = fgnc_pkg::NORM_W;
	localparam int DW    = fgnc_pkg::ID_W;
	localparam int DEPTH = CLASS_LIMIT - 2;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (CW > DW) ? CW : DW;

	localparam logic [IW-1:0] GX_C  = IW'(GRID_X);
	localparam logic [IW-1:0] GY_C  = IW'(GRID_Y);
	localparam logic [IW-1:0] GZ_C  = IW'(GRID_Z);
	localparam logic [IW-1:0] GXY_C = IW'(GRID_X * GRID_Y);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SQUARE, S_SEARCH, S_FINISH} state_t;

	state_t                 state_q;
	logic [1:0]             step_q;
	logic                   first_q;
	logic signed [GW-1:0]   gx_q, gy_q, gz_q;
	logic signed [WW-1:0]   wx_q, wy_q, wz_q;
	logic [IW-1:0]          idx_q;
	logic [NW-1:0]          prod_s1;
	logic [NW-1:0]          acc_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [CW-1:0]          ptr_q;
	logic                   cmp_v_s1;
	logic [CW-1:0]          cmp_idx_s1;
	logic [NW-1:0]          rd_s1;
	logic [DW-1:0]          id_q;
	logic                   oval_q;
	logic [IW-1:0]          res_idx_q;
	logic [NW-1:0]          res_norm_q;
	logic [DW-1:0]          res_id_q;
	logic                   res_ovf_q;

	logic [NW-1:0]          mem [DEPTH];

	logic signed [WW-1:0]   wsel;
	logic [WW-1:0]          mag;
	logic [IW-1:0]          xw, yw, zw, lin;
	logic                   hit, miss_done, mem_we;
	logic [CW-1:0]          hit_id, new_id;
	logic [XW-1:0]          hit_id_x, new_id_x;

	assign item.ready = (state_q == S_IDLE);

	assign result.valid          = oval_q;
	assign result.buffer_index   = res_idx_q;
	assign result.norm_squared   = res_norm_q;
	assign result.class_id       = res_id_q;
	assign result.class_overflow = res_ovf_q;

	// coordinate wrap and linear index, modulo the index width
	always_comb begin
		xw  = {{(IW-GW){gx_q[GW-1]}}, gx_q} + (gx_q[GW-1] ? GX_C : '0);
		yw  = {{(IW-GW){gy_q[GW-1]}}, gy_q} + (gy_q[GW-1] ? GY_C : '0);
		zw  = {{(IW-GW){gz_q[GW-1]}}, gz_q} + (gz_q[GW-1] ? GZ_C : '0);
		lin = IW'(GXY_C * zw) + IW'(GX_C * yw) + xw;
	end

	// shared squaring operand
	always_comb begin
		case (step_q)
			2'd0:    wsel = wx_q;
			2'd1:    wsel = wy_q;
			default: wsel = wz_q;
		endcase
		mag = wsel[WW-1] ? WW'(-wsel) : WW'(wsel);
	end

	always_comb begin
		hit       = cmp_v_s1 && (rd_s1 == acc_q);
		miss_done = !cmp_v_s1 && (ptr_q == count_q);
		mem_we    = (state_q == S_SEARCH) && miss_done && (count_q < DEPTH_C);
		hit_id    = cmp_idx_s1 + CW'(1);
		new_id    = count_q + CW'(1);
		hit_id_x  = XW'(hit_id);
		new_id_x  = XW'(new_id);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= acc_q;
		end
		rd_s1 <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			ptr_q    <= '0;
			cmp_v_s1 <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			if (oval_q && result.ready && (state_q != S_FINISH)) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						first_q <= item.first_of_set;
						gx_q    <= item.grid_x;
						gy_q    <= item.grid_y;
						gz_q    <= item.grid_z;
						wx_q    <= item.wave_x;
						wy_q    <= item.wave_y;
						wz_q    <= item.wave_z;
						step_q  <= '0;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					prod_s1 <= NW'(mag * mag);
					step_q  <= step_q + 2'd1;
					case (step_q)
						2'd0: idx_q <= {lin[IW-2:0], 1'b0};
						2'd1: acc_q <= prod_s1;
						default: acc_q <= acc_q + prod_s1;
					endcase
					if (step_q == 2'd3) begin
						ptr_q    <= '0;
						cmp_v_s1 <= 1'b0;
						if (first_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							id_q    <= '0;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						id_q     <= hit_id_x[DW-1:0];
						cmp_v_s1 <= 1'b0;
						state_q  <= S_FINISH;
					end else if (ptr_q != count_q) begin
						cmp_v_s1   <= 1'b1;
						cmp_idx_s1 <= ptr_q;
						ptr_q      <= ptr_q + CW'(1);
					end else if (cmp_v_s1) begin
						cmp_v_s1 <= 1'b0;
					end else begin
						if (count_q < DEPTH_C) begin
							count_q <= new_id;
							id_q    <= new_id_x[DW-1:0];
						end else begin
							ovf_q <= 1'b1;
							id_q  <= '0;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!oval_q || result.ready) begin
						oval_q     <= 1'b1;
						res_idx_q  <= idx_q;
						res_norm_q <= acc_q;
						res_id_q   <= id_q;
						res_ovf_q  <= ovf_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FGNC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready, !item.ready)
	`FGNC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	`FGNC_ASSERT_NOW(a_ovf_only_when_full, clk, arst_n, ovf_q, count_q == DEPTH_C)
	`FGNC_ASSERT_NOW(a_table_write_in_search, clk, arst_n, mem_we, !cmp_v_s1 && !first_q)
endmodule
`default_nettype wire
